FILE: rtl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types and fixed-point constants of the YUV 4:4:4 to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

    // Pipeline depth from input register to output register
    localparam int unsigned STAGES = 4;

    // Studio-range (CCIR) scale factors, 16.16
    localparam logic signed [18:0] STU_YSCALE = 19'sd76309;
    localparam logic signed [18:0] STU_CSCALE = 19'sd69923;

    // Studio-range color coefficients (carry the 255/219 factor)
    localparam logic signed [18:0] STU_CRV = 19'sd107062;
    localparam logic signed [18:0] STU_CBU = 19'sd135067;
    localparam logic signed [18:0] STU_CGU = 19'sd26250;
    localparam logic signed [18:0] STU_CGV = 19'sd54485;

    // Full-range color coefficients
    localparam logic signed [18:0] FUL_CRV = 19'sd91947;
    localparam logic signed [18:0] FUL_CBU = 19'sd115999;
    localparam logic signed [18:0] FUL_CGU = 19'sd22544;
    localparam logic signed [18:0] FUL_CGV = 19'sd46793;

    // Luma black level in studio range
    localparam logic [9:0] LUMA_BLACK = 10'd16;

    // Pipeline control handed from the handshake logic to the datapath
    typedef struct packed {
        logic adv;         // all stages shift this cycle
        logic full_range;  // mode captured with the incoming pixel
    } y2r_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/y2r_datapath.sv
// ----------------------------------------------------------------------------
// y2r_datapath
// Four-stage fixed-point datapath: range scaling, color products,
// sums, and saturation to bytes. Payload only; valid bits live upstream.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_datapath (
    input  wire                   aclk,
    input  wire y2r_pkg::y2r_ctrl_t ctrl,
    input  wire  [7:0]            luma,
    input  wire  [7:0]            blue_diff,
    input  wire  [7:0]            red_diff,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue
);

    // Saturate a signed 12-bit value to 0..255
    function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
        logic [7:0] res;
        if (v[11]) begin
            res = 8'd0;
        end else if (v[10:8] != 3'd0) begin
            res = 8'hFF;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // ---------------- stage 1: offset removal and range scale products
    logic signed [9:0]  y_off;
    logic signed [7:0]  u_c, v_c;

    logic               mode1_reg;
    logic [7:0]         luma1_reg;
    logic signed [7:0]  u1_reg, v1_reg;
    logic signed [27:0] py1_reg, pu1_reg, pv1_reg;

    // x - 128 on a byte is just the top bit inverted
    assign y_off = $signed({2'b00, luma} - y2r_pkg::LUMA_BLACK);
    assign u_c   = $signed({~blue_diff[7], blue_diff[6:0]});
    assign v_c   = $signed({~red_diff[7], red_diff[6:0]});

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            mode1_reg <= ctrl.full_range;
            luma1_reg <= luma;
            u1_reg    <= u_c;
            v1_reg    <= v_c;
            py1_reg   <= 28'(y_off * y2r_pkg::STU_YSCALE);
            pu1_reg   <= 28'(u_c * y2r_pkg::STU_CSCALE);
            pv1_reg   <= 28'(v_c * y2r_pkg::STU_CSCALE);
        end
    end

    // ---------------- stage 2: mode select and color products
    logic signed [9:0]  y2_sel;
    logic signed [8:0]  u2_sel, v2_sel;
    logic signed [18:0] crv, cbu, cgu, cgv;

    logic signed [9:0]  y2_reg;
    logic signed [27:0] pr2_reg, pb2_reg, pgv2_reg, pgu2_reg;

    // floor shift by 16 is a slice of the two's complement product
    always_comb begin
        if (mode1_reg) begin
            y2_sel = $signed({2'b00, luma1_reg});
            u2_sel = $signed({u1_reg[7], u1_reg});
            v2_sel = $signed({v1_reg[7], v1_reg});
            crv    = y2r_pkg::FUL_CRV;
            cbu    = y2r_pkg::FUL_CBU;
            cgu    = y2r_pkg::FUL_CGU;
            cgv    = y2r_pkg::FUL_CGV;
        end else begin
            y2_sel = py1_reg[25:16];
            u2_sel = pu1_reg[24:16];
            v2_sel = pv1_reg[24:16];
            crv    = y2r_pkg::STU_CRV;
            cbu    = y2r_pkg::STU_CBU;
            cgu    = y2r_pkg::STU_CGU;
            cgv    = y2r_pkg::STU_CGV;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            y2_reg   <= y2_sel;
            pr2_reg  <= 28'(v2_sel * crv);
            pb2_reg  <= 28'(u2_sel * cbu);
            pgv2_reg <= 28'(v2_sel * cgv);
            pgu2_reg <= 28'(u2_sel * cgu);
        end
    end

    // ---------------- stage 3: sums with luma
    logic signed [25:0] g_sum;
    logic signed [11:0] y_ext;
    logic signed [11:0] r3_reg, g3_reg, b3_reg;

    assign g_sum = $signed(pgv2_reg[25:0]) + $signed(pgu2_reg[25:0]);
    assign y_ext = {{2{y2_reg[9]}}, y2_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            r3_reg <= y_ext + $signed({{2{pr2_reg[25]}}, pr2_reg[25:16]});
            b3_reg <= y_ext + $signed({{2{pb2_reg[25]}}, pb2_reg[25:16]});
            g3_reg <= y_ext - $signed({{2{g_sum[25]}}, g_sum[25:16]});
        end
    end

    // ---------------- stage 4: saturation, output register
    logic [7:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            red_reg   <= clamp_byte(r3_reg);
            green_reg <= clamp_byte(g3_reg);
            blue_reg  <= clamp_byte(b3_reg);
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

FILE: rtl/yuv444_to_rgb_converter.sv
// An accepted pixel's result is valid on the m_ side from the last stage.
// Throughput: one pixel per clock; the four-stage datapath shifts as a whole
// whenever the output register is empty or its transaction completes.
// Reset (aresetn low, synchronous) empties all stages and selects
// studio range; payload registers are not reset.
// ----------------------------------------------------------------------------
// yuv444_to_rgb_converter
// BT.601 YCbCr 4:4:4 to RGB, 16.16 fixed point, studio or full range.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv444_to_rgb_converter (
    input  wire        aclk,
    input  wire        aresetn,
    // configuration
    input  wire        cfg_wr_en,
    input  wire        cfg_wr_data,
    // input pixel
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [7:0] s_luma,
    input  wire  [7:0] s_blue_diff,
    input  wire  [7:0] s_red_diff,
    // output pixel
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue
);

    localparam int unsigned NS = y2r_pkg::STAGES;

    logic              full_range_reg;
    logic [NS-1:0]     vld_reg, vld_next;
    logic              adv;
    y2r_pkg::y2r_ctrl_t ctrl;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_range_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            full_range_reg <= cfg_wr_data;
        end
    end

    // Whole pipeline moves unless the output holds an untaken result
    assign adv      = !vld_reg[NS-1] || m_ready;
    assign vld_next = {vld_reg[NS-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv;
    assign m_valid = vld_reg[NS-1];

    assign ctrl.adv        = adv;
    assign ctrl.full_range = full_range_reg;

    y2r_datapath u_datapath (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .luma      (s_luma),
        .blue_diff (s_blue_diff),
        .red_diff  (s_red_diff),
        .red       (m_red),
        .green     (m_green),
        .blue      (m_blue)
    );

    // ---------------- assertions
    // an accepted pixel occupies the first stage next cycle
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted pixel missing from stage 1");

    // a stall freezes every valid bit
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    // a pixel in the third stage reaches the output when the pipe advances
    a_reach_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[NS-2]) |=> m_valid)
        else $error("pixel lost before the output stage");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
